[design/asw_pkg.sv]
package asw_pkg;

  localparam int REG_IDX_BITS = 2;
  localparam int AMT_BITS     = 16;

  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_AMOUNT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MODE   = 2'd2;

  localparam logic [1:0] MODE_TAPE    = 2'd0;
  localparam logic [1:0] MODE_TUBE    = 2'd1;
  localparam logic [1:0] MODE_DIGITAL = 2'd2;

  localparam logic [AMT_BITS-1:0] AMT_ONE   = 16'd32768;
  localparam logic [AMT_BITS-1:0] AMT_RESET = 16'd16384;

  localparam longint TANH_E_ONE = 64'sd2147483648;

  // e = r^k in Q0.31, products truncated
  function automatic longint tanh_decay(int k, longint r);
    longint e;
    e = TANH_E_ONE;
    for (int i = 0; i < k; i++) begin
      e = (e * r) >>> 31;
    end
    return e;
  endfunction

endpackage

[design/audio_saturation_waveshaper.sv]
// Saturation waveshaper, one signed Q4.(SAMPLE_BITS-4) audio sample per request.
// Input channel: in_valid / in_stall with sample_in and block_end_in; a request
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with sample_out and block_end_out; the
// result holds while out_stall is high.
// Config: cfg_write with cfg_index 0 enable, 1 amount (Q1.15), 2 shape mode.
// Write config only with the pipeline empty.
// Throughput: one request per cycle while in_stall is low, ten stage pipeline.
// The result is registered through stages 1 to 10 in order before it is shown.
// A stalled output lets empty stages fill up; in_stall rises only when all
// ten stages hold a request and out_stall is high.
// Reset (rst, synchronous) empties the pipeline and sets enable 1,
// amount 0.5, shape mode tape. The digital clip threshold follows the amount
// register through the thr_m/thr_prod registers and then the thr register.
module audio_saturation_waveshaper #(
  parameter int SAMPLE_BITS   = 24,
  parameter int TANH_SEGMENTS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [asw_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [asw_pkg::AMT_BITS-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic                                  block_end_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic                                  block_end_out
);
  import asw_pkg::*;

  localparam int W      = SAMPLE_BITS;
  localparam int F      = W - 4;
  localparam int GW     = W + 2;
  localparam int PW     = W + GW + 1;
  localparam int TI     = $clog2(TANH_SEGMENTS + 1);
  localparam int TW     = F + 1;
  localparam int DW     = F + 2;
  localparam int IW     = DW + W;
  localparam int BW     = W + AMT_BITS + 1;
  localparam int SW     = BW + 1;
  localparam int NW     = AMT_BITS + F + 1;
  localparam int MW     = NW - 16;
  localparam int ThrK   = MW + 2;
  localparam int Stages = 10;

  localparam longint QOne      = 64'sd1 <<< F;
  localparam longint TanhStep  = (64'sd16 <<< 31) / TANH_SEGMENTS;
  localparam longint ThrRecip  = (64'sd1 <<< ThrK) / 5;
  localparam longint ThrBias   = 64'sd163840;
  localparam longint SMaxL     = (64'sd1 <<< (W - 1)) - 1;
  localparam longint SMinL     = -(64'sd1 <<< (W - 1));

  // r = exp(-16/segs) by a series up to the 20th power in Q0.31
  localparam longint TanhT1  = (TANH_E_ONE * TanhStep) >>> 31;
  localparam longint TanhT2  = ((TanhT1 * TanhStep) >>> 31) / 2;
  localparam longint TanhT3  = ((TanhT2 * TanhStep) >>> 31) / 3;
  localparam longint TanhT4  = ((TanhT3 * TanhStep) >>> 31) / 4;
  localparam longint TanhT5  = ((TanhT4 * TanhStep) >>> 31) / 5;
  localparam longint TanhT6  = ((TanhT5 * TanhStep) >>> 31) / 6;
  localparam longint TanhT7  = ((TanhT6 * TanhStep) >>> 31) / 7;
  localparam longint TanhT8  = ((TanhT7 * TanhStep) >>> 31) / 8;
  localparam longint TanhT9  = ((TanhT8 * TanhStep) >>> 31) / 9;
  localparam longint TanhT10 = ((TanhT9 * TanhStep) >>> 31) / 10;
  localparam longint TanhT11 = ((TanhT10 * TanhStep) >>> 31) / 11;
  localparam longint TanhT12 = ((TanhT11 * TanhStep) >>> 31) / 12;
  localparam longint TanhT13 = ((TanhT12 * TanhStep) >>> 31) / 13;
  localparam longint TanhT14 = ((TanhT13 * TanhStep) >>> 31) / 14;
  localparam longint TanhT15 = ((TanhT14 * TanhStep) >>> 31) / 15;
  localparam longint TanhT16 = ((TanhT15 * TanhStep) >>> 31) / 16;
  localparam longint TanhT17 = ((TanhT16 * TanhStep) >>> 31) / 17;
  localparam longint TanhT18 = ((TanhT17 * TanhStep) >>> 31) / 18;
  localparam longint TanhT19 = ((TanhT18 * TanhStep) >>> 31) / 19;
  localparam longint TanhT20 = ((TanhT19 * TanhStep) >>> 31) / 20;
  localparam longint TanhR   = TANH_E_ONE - TanhT1 + TanhT2 - TanhT3 + TanhT4
                               - TanhT5 + TanhT6 - TanhT7 + TanhT8 - TanhT9
                               + TanhT10 - TanhT11 + TanhT12 - TanhT13 + TanhT14
                               - TanhT15 + TanhT16 - TanhT17 + TanhT18 - TanhT19
                               + TanhT20;

  localparam logic signed [PW-1:0] PHalf15 = PW'(64'sd1 <<< 14);
  localparam logic signed [PW-1:0] PHalfF  = PW'(64'sd1 <<< (F - 1));
  localparam logic signed [PW-1:0] PMax    = PW'(SMaxL);
  localparam logic signed [PW-1:0] PMin    = PW'(SMinL);
  localparam logic signed [IW-1:0] IHalf   = IW'(64'sd1 <<< (W - 2));
  localparam logic signed [SW-1:0] SHalf15 = SW'(64'sd1 <<< 14);
  localparam logic signed [SW-1:0] SMax    = SW'(SMaxL);
  localparam logic signed [SW-1:0] SMin    = SW'(SMinL);

  // config registers
  logic                enable_flag;
  logic [AMT_BITS-1:0] amount_level;
  logic [1:0]          shape_mode;
  logic [AMT_BITS-1:0] amt;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_flag  <= 1'b1;
      amount_level <= AMT_RESET;
      shape_mode   <= MODE_TAPE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE: enable_flag  <= cfg_data[0];
        REG_AMOUNT: amount_level <= cfg_data;
        REG_MODE:   shape_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign amt = (amount_level > AMT_ONE) ? AMT_ONE : amount_level;

  // digital clip threshold: ONE + round(a*ONE / 327680), divide by 5 via reciprocal
  logic [NW-1:0]   thr_num;
  logic [MW-1:0]   thr_m_next;
  logic [MW-1:0]   thr_m;
  logic [2*MW-1:0] thr_prod;
  logic [MW-1:0]   thr_qe;
  logic [MW-1:0]   thr_rem;
  logic [MW-1:0]   thr_q;
  logic [W-1:0]    thr_next;
  logic [W-1:0]    thr;

  assign thr_num    = {1'b0, amt, {F{1'b0}}} + NW'(ThrBias);
  assign thr_m_next = thr_num[NW-1:16];
  assign thr_qe     = MW'(thr_prod >> ThrK);
  assign thr_rem    = thr_m - MW'({thr_qe, 2'b00}) - thr_qe;
  assign thr_q      = (thr_rem >= MW'(5)) ? thr_qe + MW'(1) : thr_qe;
  assign thr_next   = W'(QOne) + W'(thr_q);

  always_ff @(posedge clk) begin
    thr_m    <= thr_m_next;
    thr_prod <= thr_m_next * MW'(ThrRecip);
    thr      <= thr_next;
  end

  // tanh table over [0, 8.0]: (1-e)/(1+e), e = r^k
  logic [TW-1:0] tanh_tab [TANH_SEGMENTS+1];

  for (genvar k = 0; k <= TANH_SEGMENTS; k++) begin : g_tab
    localparam longint TabE   = tanh_decay(k, TanhR);
    localparam longint TabNum = (TANH_E_ONE - TabE) <<< F;
    localparam longint TabDen = TANH_E_ONE + TabE;
    localparam longint TabVal = (TabNum + (TabDen >>> 1)) / TabDen;
    assign tanh_tab[k] = TW'(TabVal);
  end

  // pipeline control
  logic v  [1:Stages];
  logic ce [1:Stages+1];
  logic be [1:Stages];
  logic signed [W-1:0] xs [1:Stages-1];

  always_comb begin
    ce[Stages+1] = !out_stall;
    for (int i = Stages; i >= 1; i--) begin
      ce[i] = !v[i] || ce[i+1];
    end
  end

  assign in_stall = !ce[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= Stages; i++) begin
        v[i] <= 1'b0;
      end
    end else begin
      if (ce[1]) begin
        v[1] <= in_valid;
      end
      for (int i = 2; i <= Stages; i++) begin
        if (ce[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      xs[1] <= sample_in;
      be[1] <= block_end_in;
    end
    for (int i = 2; i <= Stages - 1; i++) begin
      if (ce[i]) begin
        xs[i] <= xs[i-1];
      end
    end
    for (int i = 2; i <= Stages; i++) begin
      if (ce[i]) begin
        be[i] <= be[i-1];
      end
    end
  end

  // stage 1: a*|x|
  logic [W-1:0]          ax;
  logic [AMT_BITS+W-1:0] s1_tprod;

  assign ax = W'(sample_in[W-1] ? -sample_in : sample_in);

  // stage 2: gain
  logic [AMT_BITS+W-1:0] t_sum;
  logic [GW-1:0]         g_next;
  logic [GW-1:0]         s2_g;

  assign t_sum  = s1_tprod + (AMT_BITS+W)'(1 << 14);
  assign g_next = (shape_mode == MODE_TUBE) ? GW'(QOne) + GW'(t_sum >> 15)
                                            : GW'(AMT_ONE) + GW'({amt, 2'b00});

  // stage 3: x*gain
  logic signed [PW-1:0] s3_p;

  // stage 4: rounded and saturated tanh argument
  logic signed [PW-1:0] r15;
  logic signed [PW-1:0] rf;
  logic signed [PW-1:0] rsel;
  logic signed [PW-1:0] rsat;
  logic signed [W-1:0]  s4_arg;

  assign r15  = (s3_p + PHalf15) >>> 15;
  assign rf   = (s3_p + PHalfF) >>> F;
  assign rsel = (shape_mode == MODE_TUBE) ? rf : r15;
  assign rsat = (rsel > PMax) ? PMax : ((rsel < PMin) ? PMin : rsel);

  // stage 5: segment index and fraction
  logic [W-1:0]    mag_arg;
  logic [W+TI-1:0] pos;
  logic [TI:0]     idx_full;
  logic            seg_sat;
  logic [TI-1:0]   s5_idx;
  logic [W-2:0]    s5_frac;
  logic            s5_neg;
  logic            s5_sat;

  assign mag_arg  = W'(s4_arg[W-1] ? -s4_arg : s4_arg);
  assign pos      = (W+TI)'(mag_arg) * (W+TI)'(TANH_SEGMENTS);
  assign idx_full = pos[W+TI-1:W-1];
  assign seg_sat  = idx_full >= (TI+1)'(TANH_SEGMENTS);

  // stage 6: table read
  logic [TW-1:0] s6_lo;
  logic [TW-1:0] s6_hi;
  logic [W-2:0]  s6_frac;
  logic          s6_neg;
  logic          s6_sat;

  // stage 7: slope times fraction
  logic signed [DW-1:0] diff;
  logic signed [IW-1:0] s7_prod;
  logic [TW-1:0]        s7_lo;
  logic                 s7_neg;
  logic                 s7_sat;

  assign diff = $signed({1'b0, s6_hi}) - $signed({1'b0, s6_lo});

  // stage 8: shaped value
  logic signed [IW-1:0] interp;
  logic signed [DW-1:0] tmag;
  logic signed [DW-1:0] tval;
  logic signed [W-1:0]  thr_s;
  logic signed [W-1:0]  ydig;
  logic signed [W-1:0]  y_next;
  logic signed [W-1:0]  s8_y;

  assign interp = (s7_prod + IHalf) >>> (W - 1);
  assign tmag   = s7_sat ? DW'(QOne) : $signed({1'b0, s7_lo}) + DW'(interp);
  assign tval   = s7_neg ? -tmag : tmag;
  assign thr_s  = $signed(thr);
  assign ydig   = (xs[7] > thr_s) ? thr_s : ((xs[7] < -thr_s) ? -thr_s : xs[7]);

  always_comb begin
    case (shape_mode) inside
      MODE_TAPE, MODE_TUBE: y_next = W'(tval);
      MODE_DIGITAL:         y_next = ydig;
      default:              y_next = '0;
    endcase
  end

  // stage 9: dry and wet products
  logic signed [BW-1:0] s9_dry;
  logic signed [BW-1:0] s9_wet;

  // stage 10: blend, round, saturate, or pass the dry sample when disabled
  logic signed [SW-1:0] mix;
  logic signed [SW-1:0] mix_r;
  logic signed [SW-1:0] mix_sat;
  logic signed [W-1:0]  out_next;
  logic signed [W-1:0]  s10_out;

  assign mix      = SW'(s9_dry) + SW'(s9_wet);
  assign mix_r    = (mix + SHalf15) >>> 15;
  assign mix_sat  = (mix_r > SMax) ? SMax : ((mix_r < SMin) ? SMin : mix_r);
  assign out_next = enable_flag ? W'(mix_sat) : xs[9];

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      s1_tprod <= amt * ax;
    end
    if (ce[2]) begin
      s2_g <= g_next;
    end
    if (ce[3]) begin
      s3_p <= xs[2] * $signed({1'b0, s2_g});
    end
    if (ce[4]) begin
      s4_arg <= W'(rsat);
    end
    if (ce[5]) begin
      s5_idx  <= seg_sat ? '0 : idx_full[TI-1:0];
      s5_frac <= pos[W-2:0];
      s5_neg  <= s4_arg[W-1];
      s5_sat  <= seg_sat;
    end
    if (ce[6]) begin
      s6_lo   <= tanh_tab[s5_idx];
      s6_hi   <= tanh_tab[s5_idx + TI'(1)];
      s6_frac <= s5_frac;
      s6_neg  <= s5_neg;
      s6_sat  <= s5_sat;
    end
    if (ce[7]) begin
      s7_prod <= diff * $signed({1'b0, s6_frac});
      s7_lo   <= s6_lo;
      s7_neg  <= s6_neg;
      s7_sat  <= s6_sat;
    end
    if (ce[8]) begin
      s8_y <= y_next;
    end
    if (ce[9]) begin
      s9_dry <= xs[8] * $signed({1'b0, AMT_ONE - amt});
      s9_wet <= s8_y * $signed({1'b0, amt});
    end
    if (ce[10]) begin
      s10_out <= out_next;
    end
  end

  assign out_valid     = v[Stages];
  assign sample_out    = s10_out;
  assign block_end_out = be[Stages];

endmodule

[design/asw_checker.sv]
module asw_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          block_end_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(block_end_out))
    else $error("stalled result changed or dropped");

  // input only backs up once the whole pipeline is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind audio_saturation_waveshaper asw_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_asw_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import asw_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int SEGS = 256;
  localparam int FRAC = SAMPLE_W - 4;
  localparam longint Q1 = longint'(1) <<< FRAC;
  localparam longint SMAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMIN = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 14;

  typedef struct packed {
    logic        en;
    logic [15:0] amt;
    logic [1:0]  mode;
    logic [23:0] x;
    logic        be;
    logic        fixed;
    logic [23:0] want;
  } plan_row_t;

  typedef struct packed {
    logic [23:0] sample;
    logic        be;
  } shaped_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = REG_ENABLE;
  logic [AMT_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic block_end_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic block_end_out;

  // typed-in expectation travels with the request
  logic row_fixed = 1'b0;
  logic [23:0] row_want = '0;

  logic en_q = 1'b1;
  logic [15:0] amt_q = AMT_RESET;
  logic [1:0] mode_q = MODE_TAPE;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  longint tanh_q [SEGS+1];
  shaped_t shaped_due [$];
  plan_row_t plan [25];

  audio_saturation_waveshaper #(
    .SAMPLE_BITS(SAMPLE_W),
    .TANH_SEGMENTS(SEGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .block_end_in(block_end_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .block_end_out(block_end_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void fill_tanh_table();
    longint step;
    longint term;
    longint decay;
    longint e;
    longint num;
    longint den;
    step = (longint'(16) <<< 31) / SEGS;
    term = longint'(1) <<< 31;
    decay = term;
    e = term;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * step) >>> 31) / n;
      decay = (n % 2 == 1) ? decay - term : decay + term;
    end
    for (int k = 0; k <= SEGS; k++) begin
      num = ((longint'(1) <<< 31) - e) <<< FRAC;
      den = (longint'(1) <<< 31) + e;
      tanh_q[k] = (num + den / 2) / den;
      e = (e * decay) >>> 31;
    end
  endfunction

  function automatic longint shr_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint tanh_interp(longint v);
    longint m;
    longint pos;
    longint seg;
    longint frac;
    longint y;
    m = (v < 0) ? -v : v;
    pos = m * SEGS;
    seg = pos >>> (SAMPLE_W - 1);
    frac = pos & ((longint'(1) <<< (SAMPLE_W - 1)) - 1);
    if (seg >= SEGS) begin
      y = Q1;
    end else begin
      y = tanh_q[int'(seg)] +
          shr_round((tanh_q[int'(seg) + 1] - tanh_q[int'(seg)]) * frac, SAMPLE_W - 1);
    end
    return (v < 0) ? -y : y;
  endfunction

  function automatic logic [23:0] shape_sample(logic signed [23:0] xin);
    longint x;
    longint a;
    longint y;
    longint t;
    longint thr;
    longint res;
    x = xin;
    if (!en_q) return xin;
    a = (amt_q > AMT_ONE) ? longint'(AMT_ONE) : longint'(amt_q);
    case (mode_q)
      MODE_TAPE: begin
        y = tanh_interp(clamp_sample(shr_round(x * (32768 + 4 * a), 15)));
      end
      MODE_TUBE: begin
        t = shr_round(a * ((x < 0) ? -x : x), 15);
        y = tanh_interp(clamp_sample(shr_round(x * (Q1 + t), FRAC)));
      end
      MODE_DIGITAL: begin
        thr = Q1 + ((a <<< FRAC) + 5 * 32768) / (10 * 32768);
        y = (x > thr) ? thr : ((x < -thr) ? -thr : x);
      end
      default: begin
        y = 0;
      end
    endcase
    res = clamp_sample(shr_round(x * (32768 - a) + y * a, 15));
    return res[23:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      shaped_due.push_back(row_fixed ? shaped_t'{row_want, block_end_in}
                                     : shaped_t'{shape_sample(sample_in), block_end_in});
    end
  end

  always @(posedge clk) begin
    shaped_t want;
    if (!rst && out_valid && !out_stall) begin
      if (shaped_due.size() == 0) begin
        $display("%0t: unexpected result sample_out %0d block_end_out %0b",
                 $time, sample_out, block_end_out);
        mismatches++;
      end else begin
        want = shaped_due.pop_front();
        if (sample_out !== want.sample) begin
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, $signed(want.sample), sample_out);
          mismatches++;
        end
        if (block_end_out !== want.be) begin
          $display("%0t: block_end_out expected %0b actual %0b",
                   $time, want.be, block_end_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(input logic [23:0] x, input logic be, input logic fixed,
                      input logic [23:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    block_end_in <= be;
    row_fixed <= fixed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every request has come back out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shaped_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic en, input logic [15:0] amt,
                                input logic [1:0] mode);
    cfg_write <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data <= {15'd0, en};
    @(posedge clk);
    cfg_index <= REG_AMOUNT;
    cfg_data <= amt;
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data <= {14'd0, mode};
    @(posedge clk);
    cfg_write <= 1'b0;
    en_q = en;
    amt_q = amt;
    mode_q = mode;
    // clip threshold trails the amount register
    repeat (3) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [15:0] amt;
    case ($urandom_range(6))
      0: amt = 16'd0;
      1: amt = AMT_ONE;
      2: amt = 16'hFFFF;
      3: amt = 16'($urandom_range(32769, 65535));
      default: amt = 16'($urandom_range(0, 32768));
    endcase
    write_settings($urandom_range(9) != 0, amt, 2'($urandom_range(3)));
  endtask

  function automatic logic [23:0] pick_sample();
    logic signed [23:0] v;
    case ($urandom_range(5))
      0, 1: begin
        v = 24'($urandom);
      end
      2, 3: begin
        v = 24'($urandom);
        v = v >>> $urandom_range(1, 7);
      end
      default: begin
        case ($urandom_range(4))
          0: v = 24'sh7FFFFF - 24'($urandom_range(0, 255));
          1: v = 24'sh800000 + 24'($urandom_range(0, 255));
          2: v = 24'sh100000 + 24'($urandom_range(0, 65535)) - 24'sd32768;
          3: v = -24'sh100000 + 24'($urandom_range(0, 65535)) - 24'sd32768;
          default: v = 24'($urandom_range(0, 4)) - 24'sd2;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int chunk;
    fill_tanh_table();
    plan = '{
      '{1'b1, AMT_RESET, MODE_TAPE, 24'h000000, 1'b0, 1'b1, 24'h000000},
      '{1'b1, AMT_RESET, MODE_TAPE, 24'h7FFFFF, 1'b1, 1'b0, 24'h0},
      '{1'b1, AMT_RESET, MODE_TAPE, 24'h800000, 1'b0, 1'b0, 24'h0},
      '{1'b1, AMT_RESET, MODE_TAPE, 24'h000001, 1'b1, 1'b0, 24'h0},
      '{1'b1, AMT_RESET, MODE_TAPE, 24'hFFFFFF, 1'b0, 1'b0, 24'h0},
      '{1'b1, AMT_RESET, MODE_TAPE, 24'h100000, 1'b0, 1'b0, 24'h0},
      // bypass
      '{1'b0, AMT_RESET, MODE_TAPE, 24'h800000, 1'b1, 1'b1, 24'h800000},
      '{1'b0, AMT_RESET, MODE_TAPE, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
      '{1'b0, AMT_RESET, MODE_TAPE, 24'd12345, 1'b1, 1'b1, 24'd12345},
      // zero amount is a straight wire
      '{1'b1, 16'd0, MODE_TAPE, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
      '{1'b1, 16'd0, MODE_TAPE, 24'h800000, 1'b1, 1'b1, 24'h800000},
      '{1'b1, AMT_ONE, MODE_TAPE, 24'h800000, 1'b0, 1'b1, -24'sd1048576},
      '{1'b1, AMT_ONE, MODE_TAPE, 24'h7FFFFF, 1'b1, 1'b0, 24'h0},
      '{1'b1, AMT_ONE, MODE_TAPE, 24'd300000, 1'b0, 1'b0, 24'h0},
      '{1'b1, AMT_ONE, MODE_TUBE, 24'h800000, 1'b1, 1'b1, -24'sd1048576},
      '{1'b1, AMT_ONE, MODE_TUBE, 24'd2097152, 1'b0, 1'b0, 24'h0},
      '{1'b1, AMT_ONE, MODE_TUBE, -24'sd500000, 1'b1, 1'b0, 24'h0},
      '{1'b1, AMT_RESET, MODE_TUBE, 24'h7FFFFF, 1'b0, 1'b0, 24'h0},
      '{1'b1, AMT_ONE, MODE_DIGITAL, 24'h7FFFFF, 1'b1, 1'b1, 24'd1153434},
      '{1'b1, AMT_ONE, MODE_DIGITAL, 24'h800000, 1'b0, 1'b1, -24'sd1153434},
      '{1'b1, AMT_ONE, MODE_DIGITAL, 24'd1000000, 1'b1, 1'b1, 24'd1000000},
      // amount above one clamps to one
      '{1'b1, 16'hFFFF, MODE_DIGITAL, 24'h7FFFFF, 1'b0, 1'b1, 24'd1153434},
      '{1'b1, AMT_RESET, MODE_DIGITAL, -24'sd3000000, 1'b1, 1'b0, 24'h0},
      // unused shape: wet path is zero
      '{1'b1, AMT_RESET, MODE_UNUSED, 24'h7FFFFF, 1'b0, 1'b1, 24'd4194304},
      '{1'b1, AMT_ONE, MODE_UNUSED, 24'h800000, 1'b1, 1'b1, 24'h000000}
    };
    send_idle_pct = 23;
    recv_idle_pct = 82;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      if (plan[i].en != en_q || plan[i].amt != amt_q || plan[i].mode != mode_q) begin
        drain();
        write_settings(plan[i].en, plan[i].amt, plan[i].mode);
      end
      send(plan[i].x, plan[i].be, plan[i].fixed, plan[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : ((ph == 1) ? 82 : 0);
      recv_idle_pct = (ph == 0) ? 82 : ((ph == 1) ? 23 : 0);
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        drain();
        random_settings();
        chunk = $urandom_range(30, 80);
        if (chunk > RANDOM_PER_PHASE - sent) begin
          chunk = RANDOM_PER_PHASE - sent;
        end
        repeat (chunk) begin
          send(pick_sample(), $urandom_range(7) == 0, 1'b0, 24'h0);
          sent++;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[audio_saturation_waveshaper.f]
design/asw_pkg.sv
design/audio_saturation_waveshaper.sv
design/asw_checker.sv
bench/tb.sv
